>>> design/odq_pkg.sv
// Shared types and codes for the ordered deque with key search.
// Holds the command and status codes and the transfer structs of both channels.
// No dependencies.
`timescale 1ns / 1ps

package odq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_POP_HEAD  = 3'd1,
    CMD_POP_TAIL  = 3'd2,
    CMD_FIND      = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_UPDATE    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } odq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic [31:0]        found_payload;
    logic [6:0]         occupancy;
  } odq_out_t;

endpackage

>>> design/ordered_deque_with_key_search_unit.sv
// Top level of the ordered deque with key search: control sequencer and record memory.
// Depends on odq_pkg for the command and status codes and the transfer structs.
`timescale 1ns / 1ps

// The unit holds up to DEPTH records (a signed 32-bit key and a 32-bit payload) in
// arrival order in a single circular memory with one write port and one registered
// read port. Every accepted command gives exactly one result transfer. Push, refused
// commands and unused codes go from idle straight to the response state; pops first
// pass a pop state that captures the record read. Find and update walk from the head
// one record per cycle through the read port. Remove additionally closes the gap by
// copying each later record one place forward, one record per cycle. One command is
// worked on at a time; the input stalls until its result has moved into the output
// register, which then waits for the consumer independently while the next command
// is taken.
module ordered_deque_with_key_search_unit #(
  parameter int DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  odq_pkg::odq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output odq_pkg::odq_out_t out_data_o
);
  import odq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  // Slot of the record at a given distance from the head.
  function automatic logic [IW-1:0] slot_of(logic [IW-1:0] h, logic [CW-1:0] p);
    logic [IW:0] s;
    s = {1'b0, h} + (IW+1)'(p);
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  state_e            state_q;
  logic [IW-1:0]     head_q;
  logic [CW-1:0]     count_q;
  logic [2:0]        cmd_q;
  logic [31:0]       key_q;
  logic [31:0]       pay_q;
  logic [CW-1:0]     rd_pos_q;
  logic [CW-1:0]     cmp_pos_q;
  logic              cmp_vld_q;
  logic [CW-1:0]     wr_pos_q;
  logic              wr_vld_q;
  odq_out_t          res_q;
  logic              out_valid_q;
  odq_out_t          out_q;

  logic [63:0]       store_mem [DEPTH];
  logic [63:0]       rdata_q;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [63:0]       mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;

  logic              in_fire;
  logic              out_free;
  logic              full;
  logic              empty;
  logic              hit;
  logic              shift_more;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign full        = (count_q == CW'(DEPTH));
  assign empty       = (count_q == '0);
  assign hit         = cmp_vld_q && (rdata_q[63:32] == key_q);
  assign shift_more  = ((rd_pos_q + CW'(1)) < count_q);

  // Memory port control for every state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.cmd)
            CMD_PUSH_TAIL: begin
              mem_we    = !full;
              mem_waddr = slot_of(head_q, count_q);
              mem_wdata = {in_data_i.key, in_data_i.payload};
            end
            CMD_POP_HEAD: begin
              mem_re    = !empty;
              mem_raddr = head_q;
            end
            CMD_POP_TAIL: begin
              mem_re    = !empty;
              mem_raddr = slot_of(head_q, count_q - CW'(1));
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_we    = (cmd_q == CMD_UPDATE);
          mem_waddr = slot_of(head_q, cmp_pos_q);
          mem_wdata = {rdata_q[63:32], pay_q};
        end else if (rd_pos_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_q, rd_pos_q);
        end
      end
      S_SHIFT: begin
        // The record read in the previous cycle moves one place towards the head.
        mem_we    = wr_vld_q;
        mem_waddr = slot_of(head_q, wr_pos_q);
        mem_wdata = rdata_q;
        mem_re    = shift_more;
        mem_raddr = slot_of(head_q, rd_pos_q + CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      cmd_q       <= '0;
      key_q       <= '0;
      pay_q       <= '0;
      rd_pos_q    <= '0;
      cmp_pos_q   <= '0;
      cmp_vld_q   <= 1'b0;
      wr_pos_q    <= '0;
      wr_vld_q    <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      cmp_vld_q <= 1'b0;
      wr_vld_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= in_data_i.cmd;
            key_q    <= in_data_i.key;
            pay_q    <= in_data_i.payload;
            res_q    <= '0;
            rd_pos_q <= '0;
            case (in_data_i.cmd)
              CMD_PUSH_TAIL: begin
                if (full) begin
                  res_q.status <= STAT_FULL;
                end else begin
                  count_q <= count_q + CW'(1);
                end
                state_q <= S_RESP;
              end
              CMD_POP_HEAD, CMD_POP_TAIL: begin
                if (empty) begin
                  res_q.status <= STAT_EMPTY;
                  state_q      <= S_RESP;
                end else begin
                  if (in_data_i.cmd == CMD_POP_HEAD) begin
                    head_q <= slot_of(head_q, CW'(1));
                  end
                  count_q <= count_q - CW'(1);
                  state_q <= S_POP;
                end
              end
              CMD_FIND, CMD_REMOVE, CMD_UPDATE: begin
                state_q <= S_SCAN;
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_POP: begin
          res_q.found_key     <= rdata_q[63:32];
          res_q.found_payload <= rdata_q[31:0];
          state_q             <= S_RESP;
        end
        S_SCAN: begin
          // Reads run one record ahead of the compare, so each record is compared in the
          // cycle after its read and no read is issued once a match is seen.
          if (hit) begin
            res_q.found_key     <= rdata_q[63:32];
            res_q.found_payload <= rdata_q[31:0];
            if (cmd_q == CMD_REMOVE) begin
              rd_pos_q <= cmp_pos_q;
              state_q  <= S_SHIFT;
            end else begin
              state_q <= S_RESP;
            end
          end else if (rd_pos_q >= count_q) begin
            res_q.status <= STAT_NOT_FOUND;
            state_q      <= S_RESP;
          end else begin
            cmp_vld_q <= 1'b1;
            cmp_pos_q <= rd_pos_q;
            rd_pos_q  <= rd_pos_q + CW'(1);
          end
        end
        S_SHIFT: begin
          if (shift_more) begin
            wr_vld_q <= 1'b1;
            wr_pos_q <= rd_pos_q;
            rd_pos_q <= rd_pos_q + CW'(1);
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_q           <= res_q;
            out_q.occupancy <= 7'(count_q);
            out_valid_q     <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the ordered deque with key search.
// Tracks the expected deque contents and checks every result transfer field by field.
// Depends on odq_pkg and ordered_deque_with_key_search_unit.
`timescale 1ns / 1ps

module tb_top;
  import odq_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;
  // The two command codes that the block treats as no-ops.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        payload;
  } record_t;

  typedef struct {
    odq_in_t cmd;
    bit      wait_drained;
  } queued_cmd_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  odq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall;
  odq_out_t out_data;
  logic     burst_stall = 1'b0;
  logic     hold_stall = 1'b0;

  queued_cmd_t command_queue[$];
  odq_out_t    pending_replies[$];
  record_t     deque_shadow[$];
  logic signed [31:0] key_pool [8];

  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       accepted_count = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       random_count;
  odq_out_t reply_want;

  assign out_stall = burst_stall | hold_stall;

  ordered_deque_with_key_search_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the shadow deque and returns the reply it should produce.
  function automatic odq_out_t predict_deque_reply(odq_in_t c);
    odq_out_t r;
    record_t  rec;
    int       hit;
    r = '0;
    hit = -1;
    case (c.cmd)
      CMD_PUSH_TAIL: begin
        if (deque_shadow.size() >= DEPTH) r.status = STAT_FULL;
        else deque_shadow.push_back('{key: c.key, payload: c.payload});
      end
      CMD_POP_HEAD, CMD_POP_TAIL: begin
        if (deque_shadow.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (c.cmd == CMD_POP_HEAD) rec = deque_shadow.pop_front();
          else rec = deque_shadow.pop_back();
          r.found_key = rec.key;
          r.found_payload = rec.payload;
        end
      end
      CMD_FIND, CMD_REMOVE, CMD_UPDATE: begin
        foreach (deque_shadow[i]) begin
          if (hit < 0 && deque_shadow[i].key == c.key) hit = i;
        end
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.found_key = deque_shadow[hit].key;
          r.found_payload = deque_shadow[hit].payload;
          if (c.cmd == CMD_UPDATE) deque_shadow[hit].payload = c.payload;
          if (c.cmd == CMD_REMOVE) deque_shadow.delete(hit);
        end
      end
      default: ;
    endcase
    r.occupancy = 7'(deque_shadow.size());
    return r;
  endfunction

  task automatic add_cmd(input logic [2:0] cmd, input logic signed [31:0] key,
                         input logic [31:0] payload, input bit wait_drained = 1'b0);
    queued_cmd_t q;
    q.cmd.cmd = cmd;
    q.cmd.key = key;
    q.cmd.payload = payload;
    q.wait_drained = wait_drained;
    command_queue.push_back(q);
    if (random_count >= 0) random_count++;
  endtask

  // A small pool keeps searches hitting stored keys often enough to matter.
  task automatic refresh_key_pool();
    foreach (key_pool[i]) begin
      case ($urandom_range(0, 4))
        0: key_pool[i] = 32'sh8000_0000;
        1: key_pool[i] = 32'sh7FFF_FFFF;
        2: key_pool[i] = -32'sd1;
        3: key_pool[i] = 32'($urandom_range(0, 7));
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic logic signed [31:0] next_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return CMD_PUSH_TAIL;
    if (roll < 45) return CMD_POP_HEAD;
    if (roll < 55) return CMD_POP_TAIL;
    if (roll < 70) return CMD_FIND;
    if (roll < 84) return CMD_REMOVE;
    if (roll < 97) return CMD_UPDATE;
    if (roll < 99) return CMD_SPARE_A;
    return CMD_SPARE_B;
  endfunction

  // Driver: offers queued commands, holding each one steady while the block stalls it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        pending_replies.push_back(predict_deque_reply(in_data));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (command_queue.size() != 0 &&
                     !(command_queue[0].wait_drained && pending_replies.size() != 0)) begin
          in_data <= command_queue[0].cmd;
          in_valid <= 1'b1;
          void'(command_queue.pop_front());
          if (command_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected result transfer: status %0d, found_key %0d", out_data.status,
                 out_data.found_key);
          mismatch_count++;
        end else begin
          reply_want = pending_replies.pop_front();
          if (out_data.status !== reply_want.status) begin
            $error("status: expected %0d, got %0d", reply_want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.found_key !== reply_want.found_key) begin
            $error("found_key: expected %0d, got %0d", reply_want.found_key,
                   out_data.found_key);
            mismatch_count++;
          end
          if (out_data.found_payload !== reply_want.found_payload) begin
            $error("found_payload: expected %h, got %h", reply_want.found_payload,
                   out_data.found_payload);
            mismatch_count++;
          end
          if (out_data.occupancy !== reply_want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", reply_want.occupancy,
                   out_data.occupancy);
            mismatch_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        burst_stall <= 1'b1;
      end else if (command_queue.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 15);
        burst_stall <= 1'b1;
      end else begin
        burst_stall <= 1'b0;
      end
    end
  end

  // One long hold-off on the result side, so that the block backs up into its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && accepted_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      hold_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int seq_len;
    int kind;
    random_count = -1;
    refresh_key_pool();

    // Empty-queue cases, the spare codes, then the key extremes and a duplicate key.
    add_cmd(CMD_POP_HEAD, 32'sd0, 32'h0);
    add_cmd(CMD_POP_TAIL, 32'sd0, 32'h0);
    add_cmd(CMD_FIND, 32'sd5, 32'h0);
    add_cmd(CMD_REMOVE, 32'sd5, 32'h0);
    add_cmd(CMD_UPDATE, 32'sd5, 32'hFFFF_FFFF);
    add_cmd(CMD_SPARE_A, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    add_cmd(CMD_SPARE_B, 32'sh8000_0000, 32'h0);
    add_cmd(CMD_PUSH_TAIL, 32'sh8000_0000, 32'h0);
    add_cmd(CMD_PUSH_TAIL, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    add_cmd(CMD_PUSH_TAIL, -32'sd1, 32'h5555_5555);
    add_cmd(CMD_PUSH_TAIL, 32'sd0, 32'hAAAA_AAAA);
    add_cmd(CMD_PUSH_TAIL, -32'sd1, 32'h0000_0001);
    add_cmd(CMD_SPARE_A, 32'sd0, 32'h0);
    add_cmd(CMD_FIND, -32'sd1, 32'h0);
    add_cmd(CMD_UPDATE, -32'sd1, 32'hDEAD_BEEF);
    // Removing the first match from the middle; later records move up.
    add_cmd(CMD_REMOVE, -32'sd1, 32'h0);
    add_cmd(CMD_FIND, -32'sd1, 32'h0);
    add_cmd(CMD_FIND, 32'sd12345, 32'h0);
    add_cmd(CMD_FIND, 32'sh8000_0000, 32'h0);
    add_cmd(CMD_POP_TAIL, 32'sd0, 32'h0);
    add_cmd(CMD_POP_HEAD, 32'sd0, 32'h0);

    // Random part: mostly mixed traffic, with occasional fills to full and full drains.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) refresh_key_pool();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        seq_len = DEPTH + $urandom_range(2, 6);
        add_cmd(CMD_PUSH_TAIL, next_key(), $urandom, random_count == 0);
        repeat (seq_len - 1) add_cmd(CMD_PUSH_TAIL, next_key(), $urandom);
        repeat (5) add_cmd(3'($urandom_range(CMD_FIND, CMD_UPDATE)), next_key(), $urandom);
      end else if (kind == 1) begin
        seq_len = DEPTH + $urandom_range(2, 6);
        add_cmd(CMD_POP_HEAD, next_key(), $urandom, random_count == 0);
        repeat (seq_len - 1)
          add_cmd($urandom_range(0, 1) ? CMD_POP_HEAD : CMD_POP_TAIL, next_key(), $urandom);
      end else begin
        seq_len = $urandom_range(20, 40);
        add_cmd(pick_cmd(), next_key(), $urandom,
                random_count == 0 || $urandom_range(0, 7) == 0);
        repeat (seq_len - 1) add_cmd(pick_cmd(), next_key(), $urandom);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_queue.size() != 0 || in_valid || pending_replies.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
